// File: src/crt_pkg.sv
// Shared types and constants of the CRT solver: status codes, datapath
// operations, controller states and the command and flag structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crt_pkg;

	localparam int MAX_PAIRS_DEF = 32;
	localparam int RES_W         = 63;
	localparam int MOD_W         = 62;
	localparam int DW            = 64;

	localparam logic [DW-1:0] MASK63 = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [DW-1:0] POW63  = 64'h8000_0000_0000_0000;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_OVF    = 2'd1,
		STS_NOTCOP = 2'd2,
		STS_FULL   = 2'd3
	} sts_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_STORE, OP_INIT, OP_READ, OP_ZERO, OP_DIV_LIM, OP_OVF,
		OP_MUL_PROD, OP_PROD_SET, OP_NEXT, OP_IDX_CLR, OP_DIV_PART,
		OP_SAVE_PART, OP_DIV_A, OP_EUC_INIT, OP_DIV_EUC, OP_EUC_STEP,
		OP_DIV_INV, OP_SAVE_INV, OP_DIV_RED, OP_SAVE_RED, OP_MUL_T,
		OP_MUL_TERM, OP_ACC, OP_EMIT
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CHECK, ST_P_LOOP, ST_P_TEST, ST_P_DIV, ST_P_MUL, ST_P_NEXT,
		ST_P_END, ST_S_LOOP, ST_S_PART, ST_S_PARTW, ST_S_A, ST_S_AW, ST_E_TEST,
		ST_E_W, ST_I_W, ST_R_DIV, ST_R_W, ST_M1, ST_M1W, ST_M2W, ST_S_NEXT
	} state_t;

	typedef struct packed {
		op_t  op;
		sts_t sts;
	} cmd_t;

	typedef struct packed {
		logic too_many;
		logic m_zero;
		logic idx_end;
		logic prod_over;
		logic r_zero;
		logic oldr_one;
		logic div_done;
		logic mul_done;
		logic zf;
		logic of;
	} flags_t;

endpackage

`default_nettype wire

// File: src/crt_div.sv
// Restoring divider, one quotient bit per cycle, that also forms the
// product of the quotient with an auxiliary operand modulo 2^64.
// Depends on crt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crt_div (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [crt_pkg::DW-1:0] dividend,
	input  wire logic [crt_pkg::DW-1:0] divisor,
	input  wire logic [crt_pkg::DW-1:0] aux,
	output logic      [crt_pkg::DW-1:0] quotient,
	output logic      [crt_pkg::DW-1:0] remainder,
	output logic      [crt_pkg::DW-1:0] qaux,
	output logic                        done
);

	localparam int SW = $clog2(crt_pkg::DW);

	logic [SW-1:0]            step_q;
	logic                     busy_q;
	logic                     done_q;
	logic [crt_pkg::DW-1:0]   dvd_q;
	logic [crt_pkg::DW-1:0]   dsr_q;
	logic [crt_pkg::DW-1:0]   aux_q;
	logic [crt_pkg::DW-1:0]   rem_q;
	logic [crt_pkg::DW-1:0]   qaux_q;
	logic [crt_pkg::DW:0]     sh;
	logic [crt_pkg::DW:0]     diff;
	logic                     ge;

	assign sh   = {rem_q, dvd_q[crt_pkg::DW-1]};
	assign diff = sh - {1'b0, dsr_q};
	assign ge   = (sh >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == SW'(crt_pkg::DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dividend;
			dsr_q  <= divisor;
			aux_q  <= aux;
			rem_q  <= '0;
			qaux_q <= '0;
		end else if (busy_q) begin
			dvd_q  <= {dvd_q[crt_pkg::DW-2:0], ge};
			rem_q  <= ge ? diff[crt_pkg::DW-1:0] : sh[crt_pkg::DW-1:0];
			qaux_q <= {qaux_q[crt_pkg::DW-2:0], 1'b0} + (ge ? aux_q : '0);
		end
	end

	assign quotient  = dvd_q;
	assign remainder = rem_q;
	assign qaux      = qaux_q;
	assign done      = done_q;

endmodule

`default_nettype wire

// File: src/crt_mul.sv
// Modular multiplier by double-and-add, most significant bit first,
// one modular double or add per cycle. Modulus up to 2^63, operand x below it.
// Depends on crt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crt_mul (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [crt_pkg::DW-1:0] x,
	input  wire logic [crt_pkg::DW-1:0] y,
	input  wire logic [crt_pkg::DW-1:0] n,
	output logic      [crt_pkg::DW-1:0] product,
	output logic                        done
);

	localparam int SW = $clog2(crt_pkg::DW);

	logic [SW-1:0]          bit_q;
	logic                   ph_q;
	logic                   busy_q;
	logic                   done_q;
	logic [crt_pkg::DW-1:0] x_q;
	logic [crt_pkg::DW-1:0] y_q;
	logic [crt_pkg::DW-1:0] n_q;
	logic [crt_pkg::DW-1:0] acc_q;
	logic [crt_pkg::DW:0]   t;
	logic [crt_pkg::DW:0]   t_red;

	// phase 0 doubles, phase 1 adds x when the current bit of y is set
	always_comb begin
		if (!ph_q) t = {acc_q, 1'b0};
		else       t = {1'b0, acc_q} + (y_q[crt_pkg::DW-1] ? {1'b0, x_q} : '0);
		t_red = (t >= {1'b0, n_q}) ? (t - {1'b0, n_q}) : t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q  <= '0;
			ph_q   <= 1'b0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= '0;
				ph_q   <= 1'b0;
			end else if (busy_q) begin
				ph_q <= ~ph_q;
				if (ph_q) begin
					bit_q <= bit_q + 1'b1;
					if (bit_q == SW'(crt_pkg::DW - 1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			y_q   <= y;
			n_q   <= n;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= t_red[crt_pkg::DW-1:0];
			if (ph_q) y_q <= {y_q[crt_pkg::DW-2:0], 1'b0};
		end
	end

	assign product = acc_q;
	assign done    = done_q;

endmodule

`default_nettype wire

// File: src/crt_dp.sv
// Datapath of the CRT solver: pair stores, index and count, Euclid and
// accumulation registers, divider and modular multiplier, result register.
// Depends on crt_pkg, crt_div and crt_mul.
`timescale 1ns / 1ps
`default_nettype none

module crt_dp #(
	parameter int MAX_PAIRS = crt_pkg::MAX_PAIRS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire crt_pkg::cmd_t             cmd,
	input  wire logic [crt_pkg::RES_W-1:0] residue,
	input  wire logic [crt_pkg::MOD_W-1:0] modulus,
	output crt_pkg::flags_t                flags,
	output logic      [crt_pkg::RES_W-1:0] solution,
	output logic      [1:0]                status,
	output logic                           done
);

	localparam int CNT_W = $clog2(MAX_PAIRS + 1);
	localparam int IDX_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int DW    = crt_pkg::DW;
	localparam int MW    = crt_pkg::MOD_W;

	logic [crt_pkg::RES_W-1:0] res_mem [MAX_PAIRS];
	logic [MW-1:0]             mod_mem [MAX_PAIRS];

	logic [CNT_W-1:0]          cnt_q;
	logic [CNT_W-1:0]          idx_q;
	logic                      tm_q;
	logic                      zf_q;
	logic                      of_q;
	logic                      done_q;
	logic [DW-1:0]             prod_q;
	logic [DW-1:0]             acc_q;
	logic [crt_pkg::RES_W-1:0] rd_res_q;
	logic [MW-1:0]             rd_mod_q;
	logic [DW-1:0]             part_q;
	logic [DW-1:0]             oldr_q;
	logic [DW-1:0]             r_q;
	logic [DW-1:0]             olds_q;
	logic [DW-1:0]             s_q;
	logic [MW-1:0]             inv_q;
	logic [MW-1:0]             red_q;
	logic [crt_pkg::RES_W-1:0] solution_q;
	crt_pkg::sts_t             status_q;

	logic                      div_start;
	logic [DW-1:0]             div_dvd;
	logic [DW-1:0]             div_dsr;
	logic [DW-1:0]             div_aux;
	logic [DW-1:0]             div_q;
	logic [DW-1:0]             div_rem;
	logic [DW-1:0]             div_qaux;
	logic                      div_done;
	logic                      mul_start;
	logic [DW-1:0]             mul_x;
	logic [DW-1:0]             mul_y;
	logic [DW-1:0]             mul_n;
	logic [DW-1:0]             mul_p;
	logic                      mul_done;

	logic [DW-1:0]             mod64;
	logic [DW-1:0]             res_mag;
	logic [DW-1:0]             olds_abs;
	logic [MW-1:0]             rem_m;
	logic [MW-1:0]             inv_fix;
	logic [MW-1:0]             red_fix;
	logic [DW:0]               acc_sum;
	logic [DW:0]               acc_red;

	assign mod64    = {{(DW-MW){1'b0}}, rd_mod_q};
	assign res_mag  = {1'b0, ~rd_res_q} + 64'd1;
	assign olds_abs = '0 - olds_q;
	assign rem_m    = div_rem[MW-1:0];
	// a negative value maps to modulus minus its remainder, zero stays zero
	assign inv_fix  = (olds_q[DW-1] && rem_m != '0) ? (rd_mod_q - rem_m) : rem_m;
	assign red_fix  = (rd_res_q[crt_pkg::RES_W-1] && rem_m != '0) ? (rd_mod_q - rem_m) : rem_m;
	assign acc_sum  = {1'b0, acc_q} + {1'b0, mul_p};
	assign acc_red  = (acc_sum >= {1'b0, prod_q}) ? (acc_sum - {1'b0, prod_q}) : acc_sum;

	always_comb begin
		div_start = 1'b1;
		div_dvd   = '0;
		div_dsr   = mod64;
		div_aux   = '0;
		unique case (cmd.op)
			crt_pkg::OP_DIV_LIM:  div_dvd = crt_pkg::MASK63;
			crt_pkg::OP_DIV_PART: div_dvd = prod_q;
			crt_pkg::OP_DIV_A:    div_dvd = part_q;
			crt_pkg::OP_DIV_EUC: begin
				div_dvd = oldr_q;
				div_dsr = r_q;
				div_aux = s_q;
			end
			crt_pkg::OP_DIV_INV:  div_dvd = olds_q[DW-1] ? olds_abs : olds_q;
			crt_pkg::OP_DIV_RED:  div_dvd = rd_res_q[crt_pkg::RES_W-1] ? res_mag
			                                : {1'b0, rd_res_q};
			default:              div_start = 1'b0;
		endcase
	end

	always_comb begin
		mul_start = 1'b1;
		mul_x     = part_q;
		mul_y     = {{(DW-MW){1'b0}}, inv_q};
		mul_n     = prod_q;
		unique case (cmd.op)
			crt_pkg::OP_MUL_PROD: begin
				mul_x = prod_q;
				mul_y = mod64;
				mul_n = crt_pkg::POW63;
			end
			crt_pkg::OP_MUL_T:    mul_x = part_q;
			crt_pkg::OP_MUL_TERM: begin
				mul_x = mul_p;
				mul_y = {{(DW-MW){1'b0}}, red_q};
			end
			default:              mul_start = 1'b0;
		endcase
	end

	crt_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dsr),
		.aux       (div_aux),
		.quotient  (div_q),
		.remainder (div_rem),
		.qaux      (div_qaux),
		.done      (div_done)
	);

	crt_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.x       (mul_x),
		.y       (mul_y),
		.n       (mul_n),
		.product (mul_p),
		.done    (mul_done)
	);

	// stores: write at the fill count, read registered at the index
	always_ff @(posedge clk) begin
		if (cmd.op == crt_pkg::OP_STORE && cnt_q < CNT_W'(MAX_PAIRS)) begin
			res_mem[cnt_q[IDX_W-1:0]] <= residue;
			mod_mem[cnt_q[IDX_W-1:0]] <= modulus;
		end
		if (cmd.op == crt_pkg::OP_READ) begin
			rd_res_q <= res_mem[idx_q[IDX_W-1:0]];
			rd_mod_q <= mod_mem[idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			idx_q  <= '0;
			tm_q   <= 1'b0;
			zf_q   <= 1'b0;
			of_q   <= 1'b0;
			done_q <= 1'b0;
			prod_q <= 64'd1;
			acc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (cmd.op)
				crt_pkg::OP_STORE: begin
					if (cnt_q < CNT_W'(MAX_PAIRS)) cnt_q <= cnt_q + 1'b1;
					else                           tm_q  <= 1'b1;
				end
				crt_pkg::OP_INIT: begin
					idx_q  <= '0;
					prod_q <= 64'd1;
					acc_q  <= '0;
					zf_q   <= 1'b0;
					of_q   <= 1'b0;
				end
				crt_pkg::OP_ZERO:     zf_q   <= 1'b1;
				crt_pkg::OP_OVF:      of_q   <= 1'b1;
				crt_pkg::OP_PROD_SET: prod_q <= mul_p;
				crt_pkg::OP_NEXT:     idx_q  <= idx_q + 1'b1;
				crt_pkg::OP_IDX_CLR:  idx_q  <= '0;
				crt_pkg::OP_ACC:      acc_q  <= acc_red[DW-1:0];
				crt_pkg::OP_EMIT: begin
					done_q <= 1'b1;
					cnt_q  <= '0;
					tm_q   <= 1'b0;
					prod_q <= 64'd1;
					acc_q  <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			crt_pkg::OP_SAVE_PART: part_q <= div_q;
			crt_pkg::OP_EUC_INIT: begin
				oldr_q <= div_rem;
				r_q    <= mod64;
				olds_q <= 64'd1;
				s_q    <= '0;
			end
			crt_pkg::OP_EUC_STEP: begin
				oldr_q <= r_q;
				r_q    <= div_rem;
				olds_q <= s_q;
				s_q    <= olds_q - div_qaux;
			end
			crt_pkg::OP_SAVE_INV: inv_q <= inv_fix;
			crt_pkg::OP_SAVE_RED: red_q <= red_fix;
			crt_pkg::OP_EMIT: begin
				solution_q <= (cmd.sts == crt_pkg::STS_OK) ? acc_q[crt_pkg::RES_W-1:0] : '0;
				status_q   <= cmd.sts;
			end
			default: ;
		endcase
	end

	always_comb begin
		flags.too_many  = tm_q;
		flags.m_zero    = (rd_mod_q == '0);
		flags.idx_end   = (idx_q == cnt_q);
		flags.prod_over = (prod_q > div_q);
		flags.r_zero    = (r_q == '0);
		flags.oldr_one  = (oldr_q == 64'd1);
		flags.div_done  = div_done;
		flags.mul_done  = mul_done;
		flags.zf        = zf_q;
		flags.of        = of_q;
	end

	assign solution = solution_q;
	assign status   = status_q;
	assign done     = done_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held longer than one cycle");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != crt_pkg::STS_OK) |-> (solution_q == '0))
		else $error("nonzero solution with error status");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_PAIRS))
		else $error("pair count beyond store depth");

	a_emit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == crt_pkg::OP_EMIT) |=> (cnt_q == '0 && !tm_q))
		else $error("set state not cleared after result");

endmodule

`default_nettype wire

// File: src/crt_ctrl.sv
// Controller of the CRT solver: takes items, then sequences the zero and
// product pass and the per-pair inverse and accumulate pass. Depends on crt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crt_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic            last,
	input  wire crt_pkg::flags_t flags,
	output logic                 busy,
	output crt_pkg::cmd_t        cmd
);

	crt_pkg::state_t state_q;
	crt_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= crt_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			crt_pkg::ST_IDLE:    if (start && last) state_d = crt_pkg::ST_CHECK;
			crt_pkg::ST_CHECK:   state_d = flags.too_many ? crt_pkg::ST_IDLE : crt_pkg::ST_P_LOOP;
			crt_pkg::ST_P_LOOP:  state_d = flags.idx_end ? crt_pkg::ST_P_END : crt_pkg::ST_P_TEST;
			crt_pkg::ST_P_TEST:  state_d = (flags.m_zero || flags.of) ? crt_pkg::ST_P_NEXT
			                               : crt_pkg::ST_P_DIV;
			crt_pkg::ST_P_DIV:   if (flags.div_done)
				state_d = flags.prod_over ? crt_pkg::ST_P_NEXT : crt_pkg::ST_P_MUL;
			crt_pkg::ST_P_MUL:   if (flags.mul_done) state_d = crt_pkg::ST_P_NEXT;
			crt_pkg::ST_P_NEXT:  state_d = crt_pkg::ST_P_LOOP;
			crt_pkg::ST_P_END:   state_d = (flags.zf || flags.of) ? crt_pkg::ST_IDLE
			                               : crt_pkg::ST_S_LOOP;
			crt_pkg::ST_S_LOOP:  state_d = flags.idx_end ? crt_pkg::ST_IDLE : crt_pkg::ST_S_PART;
			crt_pkg::ST_S_PART:  state_d = crt_pkg::ST_S_PARTW;
			crt_pkg::ST_S_PARTW: if (flags.div_done) state_d = crt_pkg::ST_S_A;
			crt_pkg::ST_S_A:     state_d = crt_pkg::ST_S_AW;
			crt_pkg::ST_S_AW:    if (flags.div_done) state_d = crt_pkg::ST_E_TEST;
			crt_pkg::ST_E_TEST: begin
				if (!flags.r_zero)       state_d = crt_pkg::ST_E_W;
				else if (flags.oldr_one) state_d = crt_pkg::ST_I_W;
				else                     state_d = crt_pkg::ST_IDLE;
			end
			crt_pkg::ST_E_W:     if (flags.div_done) state_d = crt_pkg::ST_E_TEST;
			crt_pkg::ST_I_W:     if (flags.div_done) state_d = crt_pkg::ST_R_DIV;
			crt_pkg::ST_R_DIV:   state_d = crt_pkg::ST_R_W;
			crt_pkg::ST_R_W:     if (flags.div_done) state_d = crt_pkg::ST_M1;
			crt_pkg::ST_M1:      state_d = crt_pkg::ST_M1W;
			crt_pkg::ST_M1W:     if (flags.mul_done) state_d = crt_pkg::ST_M2W;
			crt_pkg::ST_M2W:     if (flags.mul_done) state_d = crt_pkg::ST_S_NEXT;
			crt_pkg::ST_S_NEXT:  state_d = crt_pkg::ST_S_LOOP;
			default:             state_d = crt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op  = crt_pkg::OP_NONE;
		cmd.sts = crt_pkg::STS_OK;
		unique case (state_q)
			crt_pkg::ST_IDLE:    if (start) cmd.op = crt_pkg::OP_STORE;
			crt_pkg::ST_CHECK: begin
				if (flags.too_many) begin
					cmd.op  = crt_pkg::OP_EMIT;
					cmd.sts = crt_pkg::STS_FULL;
				end else begin
					cmd.op  = crt_pkg::OP_INIT;
				end
			end
			crt_pkg::ST_P_LOOP:  if (!flags.idx_end) cmd.op = crt_pkg::OP_READ;
			crt_pkg::ST_P_TEST: begin
				if (flags.m_zero)   cmd.op = crt_pkg::OP_ZERO;
				else if (!flags.of) cmd.op = crt_pkg::OP_DIV_LIM;
			end
			crt_pkg::ST_P_DIV:   if (flags.div_done)
				cmd.op = flags.prod_over ? crt_pkg::OP_OVF : crt_pkg::OP_MUL_PROD;
			crt_pkg::ST_P_MUL:   if (flags.mul_done) cmd.op = crt_pkg::OP_PROD_SET;
			crt_pkg::ST_P_NEXT:  cmd.op = crt_pkg::OP_NEXT;
			crt_pkg::ST_P_END: begin
				// a zero modulus outranks product overflow
				if (flags.zf) begin
					cmd.op  = crt_pkg::OP_EMIT;
					cmd.sts = crt_pkg::STS_NOTCOP;
				end else if (flags.of) begin
					cmd.op  = crt_pkg::OP_EMIT;
					cmd.sts = crt_pkg::STS_OVF;
				end else begin
					cmd.op  = crt_pkg::OP_IDX_CLR;
				end
			end
			crt_pkg::ST_S_LOOP:  cmd.op = flags.idx_end ? crt_pkg::OP_EMIT : crt_pkg::OP_READ;
			crt_pkg::ST_S_PART:  cmd.op = crt_pkg::OP_DIV_PART;
			crt_pkg::ST_S_PARTW: if (flags.div_done) cmd.op = crt_pkg::OP_SAVE_PART;
			crt_pkg::ST_S_A:     cmd.op = crt_pkg::OP_DIV_A;
			crt_pkg::ST_S_AW:    if (flags.div_done) cmd.op = crt_pkg::OP_EUC_INIT;
			crt_pkg::ST_E_TEST: begin
				if (!flags.r_zero) begin
					cmd.op  = crt_pkg::OP_DIV_EUC;
				end else if (flags.oldr_one) begin
					cmd.op  = crt_pkg::OP_DIV_INV;
				end else begin
					cmd.op  = crt_pkg::OP_EMIT;
					cmd.sts = crt_pkg::STS_NOTCOP;
				end
			end
			crt_pkg::ST_E_W:     if (flags.div_done) cmd.op = crt_pkg::OP_EUC_STEP;
			crt_pkg::ST_I_W:     if (flags.div_done) cmd.op = crt_pkg::OP_SAVE_INV;
			crt_pkg::ST_R_DIV:   cmd.op = crt_pkg::OP_DIV_RED;
			crt_pkg::ST_R_W:     if (flags.div_done) cmd.op = crt_pkg::OP_SAVE_RED;
			crt_pkg::ST_M1:      cmd.op = crt_pkg::OP_MUL_T;
			crt_pkg::ST_M1W:     if (flags.mul_done) cmd.op = crt_pkg::OP_MUL_TERM;
			crt_pkg::ST_M2W:     if (flags.mul_done) cmd.op = crt_pkg::OP_ACC;
			crt_pkg::ST_S_NEXT:  cmd.op = crt_pkg::OP_NEXT;
			default: ;
		endcase
	end

	assign busy = (state_q != crt_pkg::ST_IDLE);

endmodule

`default_nettype wire

// File: src/crt_solver_core.sv
// Top level of the CRT solver: controller and datapath.
// Depends on crt_pkg, crt_ctrl and crt_dp.
//
// Each item carries one residue and modulus pair and is taken when start is
// high and busy is low; an item without last leaves busy low and gives no
// result. The item with last starts the solve, busy stays high until the
// result, and solution and status then appear for exactly one cycle with
// done high; the receiver must take it then. The solve runs on one restoring
// divider and one modular multiplier, with Euclid steps up to about 90 per
// pair for the widest moduli. Pairs beyond MAX_PAIRS are dropped and the
// set ends with status 3; status 1 is product overflow, status 2 a zero or
// shared factor.
`timescale 1ns / 1ps
`default_nettype none

module crt_solver_core #(
	parameter int MAX_PAIRS = crt_pkg::MAX_PAIRS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [crt_pkg::RES_W-1:0] residue,
	input  wire logic [crt_pkg::MOD_W-1:0] modulus,
	input  wire logic                      last,
	output logic      [crt_pkg::RES_W-1:0] solution,
	output logic      [1:0]                status,
	output logic                           done
);

	crt_pkg::cmd_t   cmd;
	crt_pkg::flags_t flags;

	crt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (last),
		.flags  (flags),
		.busy   (busy),
		.cmd    (cmd)
	);

	crt_dp #(
		.MAX_PAIRS (MAX_PAIRS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.residue  (residue),
		.modulus  (modulus),
		.flags    (flags),
		.solution (solution),
		.status   (status),
		.done     (done)
	);

endmodule

`default_nettype wire

// File: verif/crt_checker.sv
// Checker for crt_solver_core: watches the item and result ports, predicts
// each solution and status, and compares them in order. Depends on crt_pkg.
`timescale 1ns / 1ps

module crt_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic [crt_pkg::RES_W-1:0] residue,
	input  logic [crt_pkg::MOD_W-1:0] modulus,
	input  logic                      last,
	input  logic [crt_pkg::RES_W-1:0] solution,
	input  logic [1:0]                status,
	input  logic                      done,
	output int                        fails,
	output int                        pending
);
	localparam int RES_W = crt_pkg::RES_W;
	localparam int MOD_W = crt_pkg::MOD_W;

	typedef struct packed {
		logic [RES_W-1:0] sol;
		crt_pkg::sts_t    sts;
	} answer_t;

	logic [RES_W-1:0] res_mem [crt_pkg::MAX_PAIRS_DEF];
	logic [MOD_W-1:0] mod_mem [crt_pkg::MAX_PAIRS_DEF];
	int               held;
	bit               overfull;
	answer_t          answers [$];

	function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
		logic [63:0] acc;
		acc = 0;
		x = x % m;
		while (y != 0) begin
			if (y[0])
				acc = (acc + x) % m;
			x = (x + x) % m;
			y = y >> 1;
		end
		return acc;
	endfunction

	function automatic bit inv_mod(logic [63:0] a, logic [63:0] m, output logic [63:0] inv);
		logic [63:0] old_r, r, old_s, s, q, t, mag;
		old_r = a % m;
		r     = m;
		old_s = 1;
		s     = 0;
		inv   = 0;
		while (r != 0) begin
			q     = old_r / r;
			t     = old_r - q * r;
			old_r = r;
			r     = t;
			t     = old_s - q * s;
			old_s = s;
			s     = t;
		end
		if (old_r != 1)
			return (m == 1);
		if (old_s[63]) begin
			mag = (64'd0 - old_s) % m;
			inv = (mag == 0) ? 64'd0 : m - mag;
		end else begin
			inv = old_s % m;
		end
		return 1;
	endfunction

	function automatic logic [63:0] fold_residue(logic [RES_W-1:0] raw, logic [63:0] m);
		logic [63:0] mag, rem;
		if (raw[RES_W-1]) begin
			mag = {1'b0, ~raw} + 64'd1;
			rem = mag % m;
			return (rem == 0) ? 64'd0 : m - rem;
		end
		return {1'b0, raw} % m;
	endfunction

	function automatic answer_t solve_set();
		answer_t     a;
		logic [63:0] prod, part, inv, term, acc, m;
		a.sol = 0;
		a.sts = crt_pkg::STS_OK;
		if (overfull) begin
			a.sts = crt_pkg::STS_FULL;
			return a;
		end
		for (int i = 0; i < held; i++)
			if (mod_mem[i] == 0) begin
				a.sts = crt_pkg::STS_NOTCOP;
				return a;
			end
		prod = 1;
		for (int i = 0; i < held; i++) begin
			m = {2'b0, mod_mem[i]};
			if (prod > crt_pkg::MASK63 / m) begin
				a.sts = crt_pkg::STS_OVF;
				return a;
			end
			prod = prod * m;
		end
		acc = 0;
		for (int i = 0; i < held; i++) begin
			m    = {2'b0, mod_mem[i]};
			part = prod / m;
			if (!inv_mod(part, m, inv)) begin
				a.sts = crt_pkg::STS_NOTCOP;
				return a;
			end
			term = mul_mod(mul_mod(part, inv, prod), fold_residue(res_mem[i], m), prod);
			acc  = (acc + term) % prod;
		end
		a.sol = acc[RES_W-1:0];
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t got, want;
		int      errs;
		errs = 0;
		if (!arst_n) begin
			held     = 0;
			overfull = 0;
			fails    <= 0;
			pending  <= 0;
			answers.delete();
		end else begin
			if (done) begin
				got.sol = solution;
				got.sts = crt_pkg::sts_t'(status);
				if (answers.size() == 0) begin
					$error("result with nothing expected: solution %0d status %0d",
						solution, status);
					errs++;
				end else begin
					want = answers.pop_front();
					if (got.sol !== want.sol) begin
						$error("solution expected %0d actual %0d", want.sol, got.sol);
						errs++;
					end
					if (status !== want.sts) begin
						$error("status expected %0d actual %0d", want.sts, status);
						errs++;
					end
				end
			end
			if (start && !busy) begin
				// blocking updates here so the solve sees this item
				if (held < crt_pkg::MAX_PAIRS_DEF) begin
					res_mem[held] = residue;
					mod_mem[held] = modulus;
					held = held + 1;
				end else begin
					overfull = 1;
				end
				if (last) begin
					answers.push_back(solve_set());
					held     = 0;
					overfull = 0;
				end
			end
			fails   <= fails + errs;
			pending <= answers.size();
		end
	end
endmodule

// File: verif/testbench.sv
// Top of the crt_solver_core testbench: clock, reset, item stimulus,
// watchdog and verdict. Depends on crt_pkg, crt_solver_core and crt_checker.
`timescale 1ns / 1ps

module testbench;
	localparam int RES_W = crt_pkg::RES_W;
	localparam int MOD_W = crt_pkg::MOD_W;

	localparam int QUIET_LIMIT = 1_000_000;

	logic             clk = 0;
	logic             arst_n = 0;
	logic             start = 0;
	logic [RES_W-1:0] residue = '0;
	logic [MOD_W-1:0] modulus = MOD_W'(1);
	logic             last = 0;
	logic             busy, done;
	logic [RES_W-1:0] solution;
	logic [1:0]       status;
	int               fails, pending;
	int               items = 0, sets = 0, quiet = 0;
	bit               no_gaps = 0;
	logic [63:0]      primes [22] = '{64'd1, 64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13,
		64'd17, 64'd19, 64'd23, 64'd29, 64'd31, 64'd37, 64'd41, 64'd43, 64'd47,
		64'd65537, 64'd1000003, 64'd999999937, 64'd4294967291,
		64'd2305843009213693951, 64'd53};

	always #2 clk = ~clk;

	crt_solver_core dut (.*);

	crt_checker chk (.*);

	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: no activity for %0d cycles", QUIET_LIMIT);
			$display("testbench failed");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send(logic [RES_W-1:0] r, logic [MOD_W-1:0] m, logic l);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(negedge clk);
		end
		start   <= 1;
		residue <= r;
		modulus <= m;
		last    <= l;
		do @(posedge clk); while (busy);
		@(negedge clk);
		items++;
		if (l)
			sets++;
	endtask

	// hold off until every expected result has come
	task automatic drain();
		start <= 0;
		@(negedge clk);
		while (pending != 0 || busy)
			@(negedge clk);
	endtask

	function automatic logic [MOD_W-1:0] pick_modulus(ref bit used [22]);
		int          k;
		logic [63:0] v;
		case ($urandom_range(0, 9))
			0: begin
				v = rand64();
				return v[MOD_W-1:0];
			end
			1: return MOD_W'($urandom_range(0, 200));
			default: begin
				k = $urandom_range(0, 21);
				for (int t = 0; t < 4 && used[k]; t++)
					k = $urandom_range(0, 21);
				used[k] = 1;
				v = primes[k];
				return v[MOD_W-1:0];
			end
		endcase
	endfunction

	initial begin
		bit          used [22];
		int          n;
		logic [63:0] r;
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: field extremes, modulus one, zero modulus, overflow,
		// shared factor, negative residues, store full
		send(63'h3FFF_FFFF_FFFF_FFFF, 62'h3FFF_FFFF_FFFF_FFFF, 1);
		send(63'h4000_0000_0000_0001, 62'h3FFF_FFFF_FFFF_FFFF, 1);
		send(63'h4000_0000_0000_0000, 62'd7, 1);
		send(63'd5, 62'd1, 1);
		send(63'h7FFF_FFFF_FFFF_FFFF, 62'd1, 0);
		send(63'd2, 62'd3, 0);
		send(63'd3, 62'd5, 1);
		send(63'd1, 62'd0, 1);
		send(63'd4, 62'd6, 0);
		send(63'd1, 62'd4, 1);
		send(63'd1, 62'd4294967291, 0);
		send(63'd2, 62'd4294967279, 1);
		send(63'h7FFF_FFFF_FFFF_FFFD, 62'd11, 0);
		send(63'd100, 62'd13, 0);
		send(63'd0, 62'd17, 1);
		drain();
		no_gaps = 1;
		for (int i = 0; i < 33; i++)
			send(63'(i), 62'd1, i == 32);
		no_gaps = 0;
		drain();

		while (items < 300) begin
			for (int k = 0; k < 22; k++)
				used[k] = 0;
			no_gaps = ($urandom_range(0, 3) == 0);
			n = ($urandom_range(0, 30) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 5);
			for (int i = 0; i < n; i++) begin
				r = rand64();
				if ($urandom_range(0, 3) == 0)
					r = 64'($urandom_range(0, 1000));
				send(r[RES_W-1:0], (n > 8) ? MOD_W'($urandom_range(1, 3)) : pick_modulus(used),
					i == n - 1);
			end
			if ($urandom_range(0, 9) == 0)
				drain();
		end
		no_gaps = 0;
		drain();
		repeat (100) @(negedge clk);

		$display("sent %0d items in %0d congruence sets, including store full, zero,",
			items, sets);
		$display("overflow, shared factor, modulus one and signed residue extremes");
		if (fails == 0 && pending == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule
